FILE: src/ilist_pkg.sv
// ----------------------------------------------------------------------------
// ilist_pkg
// Types, operation and status codes and the sequencer states of the ordered
// list block.
// ----------------------------------------------------------------------------
package ilist_pkg;

   localparam int ILIST_DEPTH = 64;

   // Operation codes carried in the kind field
   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_DELETE = 2'd1;
   localparam logic [1:0] KIND_SEARCH = 2'd2;

   // Result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_INDEX = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [1:0]         kind;
      logic [6:0]         position;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [5:0] found_position;
      logic [6:0] count_after;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SHIFT,
      S_DRAIN,
      S_WRITE,
      S_SCAN,
      S_SCAN_DRAIN,
      S_FINISH
   } state_type;

endpackage

FILE: src/indexed_list_insert_delete_search.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_search
// Ordered list of up to DEPTH signed 32-bit values held in one synchronous
// memory, with insert, delete and search by a memory sequencer.
// ----------------------------------------------------------------------------
// One item is worked on at a time, with one list store read per cycle. An
// insert at position p moves each entry from the last down to p one place up,
// then writes the new value at p (an append only writes); a delete moves each
// entry above p one place down (removing the last entry only lowers the
// count); a search reads from position 0 upward and stops after the first
// match; a rejected item goes straight to its result. A new item is taken
// once the previous one has placed its result in the output register, so the
// result may wait for rsp_ready while the next item runs.
// The list store has no reset; only data read from positions below the count is used.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_search #(
   parameter int DEPTH = ilist_pkg::ILIST_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ilist_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ilist_pkg::rsp_type rsp_data
);
   import ilist_pkg::*;

   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > 7) ? CW : 7;

   // List store: one read and one write port, registered read data
   logic signed [31:0] mem [DEPTH];
   logic signed [31:0] rd_data_ff;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic signed [31:0] wr_data;

   state_type     state_ff, state_in;
   req_type       req_ff, req_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] ptr_ff, ptr_in;        // next address to read
   logic [AW-1:0] last_ff, last_in;      // final address of the walk
   logic          up_ff, up_in;          // shift direction: toward the top
   logic          pend_ff, pend_in;      // read data arrives this cycle
   logic [AW-1:0] qaddr_ff, qaddr_in;    // address of that read data
   logic [1:0]    status_ff, status_in;
   logic [AW-1:0] found_ff, found_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Decode of the held item against the current count
   logic [CMPW-1:0] pos_x, cnt_x, depth_x, pos_p1, cnt_m1, found_x;
   logic            ins_bad, is_full, ins_tail, del_bad, del_tail, is_empty;
   logic            match, slot_free;

   always_comb begin
      pos_x    = CMPW'(req_ff.position);
      cnt_x    = CMPW'(count_ff);
      depth_x  = CMPW'(DEPTH);
      pos_p1   = pos_x + CMPW'(1);
      cnt_m1   = cnt_x - CMPW'(1);
      found_x  = CMPW'(found_ff);
      ins_bad  = pos_x > cnt_x;
      is_full  = cnt_x == depth_x;
      ins_tail = pos_x == cnt_x;
      del_bad  = pos_x >= cnt_x;
      del_tail = pos_p1 == cnt_x;
      is_empty = cnt_x == '0;
      match    = pend_ff && (rd_data_ff == req_ff.value);
      slot_free = !rsp_valid_ff || rsp_ready;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            case (req_ff.kind)
               KIND_INSERT: begin
                  if (ins_bad || is_full) state_in = S_FINISH;
                  else if (ins_tail)      state_in = S_WRITE;
                  else                    state_in = S_SHIFT;
               end
               KIND_DELETE: begin
                  if (del_bad || del_tail) state_in = S_FINISH;
                  else                     state_in = S_SHIFT;
               end
               KIND_SEARCH: begin
                  if (is_empty) state_in = S_FINISH;
                  else          state_in = S_SCAN;
               end
               default: state_in = S_FINISH;
            endcase
         end
         S_SHIFT: begin
            if (ptr_ff == last_ff) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            state_in = up_ff ? S_WRITE : S_FINISH;
         end
         S_WRITE: state_in = S_FINISH;
         S_SCAN: begin
            if (match)                  state_in = S_FINISH;
            else if (ptr_ff == last_ff) state_in = S_SCAN_DRAIN;
         end
         S_SCAN_DRAIN: state_in = S_FINISH;
         S_FINISH: begin
            if (slot_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs: handshake and memory port controls
   always_comb begin
      req_ready = state_ff == S_IDLE;
      rd_addr   = ptr_ff;
      wr_en     = 1'b0;
      wr_addr   = up_ff ? (qaddr_ff + AW'(1)) : (qaddr_ff - AW'(1));
      wr_data   = rd_data_ff;
      case (state_ff)
         // Move the word read last cycle one place; the read in flight is
         // two places away, so the two ports never touch the same entry.
         S_SHIFT, S_DRAIN: wr_en = pend_ff;
         S_WRITE: begin
            wr_en   = 1'b1;
            wr_addr = pos_x[AW-1:0];
            wr_data = req_ff.value;
         end
         default: wr_en = 1'b0;
      endcase
   end

   // Datapath next values
   always_comb begin
      req_in       = req_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      last_in      = last_ff;
      up_in        = up_ff;
      pend_in      = 1'b0;
      qaddr_in     = ptr_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) req_in = req_data;
         end
         S_DECODE: begin
            status_in = ST_OK;
            found_in  = '0;
            case (req_ff.kind)
               KIND_INSERT: begin
                  up_in   = 1'b1;
                  ptr_in  = cnt_m1[AW-1:0];
                  last_in = pos_x[AW-1:0];
                  if (ins_bad)      status_in = ST_BAD_INDEX;
                  else if (is_full) status_in = ST_FULL;
               end
               KIND_DELETE: begin
                  up_in   = 1'b0;
                  ptr_in  = pos_p1[AW-1:0];
                  last_in = cnt_m1[AW-1:0];
                  if (del_bad) status_in = ST_BAD_INDEX;
                  else         count_in  = count_ff - CW'(1);
               end
               KIND_SEARCH: begin
                  ptr_in  = '0;
                  last_in = cnt_m1[AW-1:0];
                  if (is_empty) status_in = ST_NOT_FOUND;
               end
               default: status_in = ST_BAD_INDEX;
            endcase
         end
         S_SHIFT: begin
            // Issue a read and step toward the end of the walk
            pend_in = 1'b1;
            if (ptr_ff != last_ff) ptr_in = up_ff ? (ptr_ff - AW'(1)) : (ptr_ff + AW'(1));
         end
         S_WRITE: count_in = count_ff + CW'(1);
         S_SCAN: begin
            pend_in = 1'b1;
            if (match)                  found_in = qaddr_ff;
            else if (ptr_ff != last_ff) ptr_in   = ptr_ff + AW'(1);
         end
         S_SCAN_DRAIN: begin
            if (match) found_in  = qaddr_ff;
            else       status_in = ST_NOT_FOUND;
         end
         S_FINISH: begin
            if (slot_free) begin
               rsp_in.status         = status_ff;
               rsp_in.found_position = found_x[5:0];
               rsp_in.count_after    = cnt_x[6:0];
               rsp_valid_in          = 1'b1;
            end
         end
         default: pend_in = 1'b0;
      endcase
   end

   // List store
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      ptr_ff    <= ptr_in;
      last_ff   <= last_in;
      up_ff     <= up_in;
      qaddr_ff  <= qaddr_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: src/ilist_checker.sv
// ----------------------------------------------------------------------------
// ilist_checker
// Port-level checks of the ordered list block, bound to its top level.
// ----------------------------------------------------------------------------
module ilist_checker #(
   parameter int DEPTH = ilist_pkg::ILIST_DEPTH
) (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input ilist_pkg::rsp_type rsp_data
);
   import ilist_pkg::*;

   // Count reported by the last taken result
   logic [6:0] last_count_ff;
   logic [6:0] count_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_count_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         last_count_ff <= rsp_data.count_after;
      end
   end

   assign count_step = rsp_data.count_after - last_count_ff;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Move the count by at most one entry, up or down, per item
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (count_step == 7'd0 || count_step == 7'd1 || count_step == 7'h7f))
      else $error("count moved by more than one entry");

   // Report a full rejection only with the list at capacity
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_FULL |-> rsp_data.count_after == 7'(DEPTH))
      else $error("full status with list not full");

   // Hold found_position at zero on every result whose status is not OK
   a_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.found_position == 6'd0)
      else $error("found_position set without a match");

   // A rejection or a miss leaves the count unchanged
   a_reject_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_BAD_INDEX || rsp_data.status == ST_NOT_FOUND ||
                    rsp_data.status == ST_FULL) |-> count_step == 7'd0)
      else $error("count changed on a rejected item");

endmodule

bind indexed_list_insert_delete_search ilist_checker #(.DEPTH(DEPTH)) u_ilist_checker (.*);
